// File: hdl/itrp_pkg.sv
// Shared types and constants for the ink-to-RGB preview pipeline.
package itrp_pkg;

  localparam int INK_FIELDS = 6;
  localparam int FIELD_W    = 16;
  localparam int COLOUR_W   = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int INK_CNT_W  = 3;
  localparam int COMPS      = 3;

  localparam int RED   = 0;
  localparam int GREEN = 1;
  localparam int BLUE  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INKS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE  = 3'd7;

  typedef struct packed {
    logic [INK_FIELDS-1:0][FIELD_W-1:0] amt;
    logic [COMPS-1:0][FIELD_W-1:0]      comp;
    logic [FIELD_W-1:0]                 alpha;
  } itrp_pix_t;

endpackage

// File: hdl/itrp_cell.sv
// One ink cell: multiplies its ink against the pixel, then folds the shade into the running minimum.
module itrp_cell import itrp_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INK_IDX     = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itrp_pix_t           in_pix,
  input  logic [COLOUR_W-1:0] colour,
  input  logic                active,
  output logic                out_valid,
  input  logic                out_ready,
  output itrp_pix_t           out_pix
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  logic                            s1_valid_r;
  itrp_pix_t                       s1_pix_r;
  logic [COMPS-1:0][PW-1:0]        s1_prod_r;
  logic [COMPS-1:0][PW-1:0]        s1_prod_nxt;
  logic                            s2_valid_r;
  itrp_pix_t                       s2_pix_r;
  itrp_pix_t                       s2_pix_nxt;
  logic                            s2_ready;
  logic [COMPS-1:0][FIELD_W-1:0]   col_c;
  logic [COMPS-1:0][PW-1:0]        quot_sum;
  logic [COMPS-1:0][SAMPLE_BITS-1:0] shade;

  assign s2_ready = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_comb begin
    for (int k = 0; k < COMPS; k++) begin
      col_c[k]       = colour[COLOUR_W-1-FIELD_W*k -: FIELD_W];
      s1_prod_nxt[k] = PW'(SMAX - col_c[k][SAMPLE_BITS-1:0]) *
                       PW'(in_pix.amt[INK_IDX][SAMPLE_BITS-1:0]);
    end
  end

  // Floor division by 2^n-1: (p + (p >> n) + 1) >> n is exact for every
  // product of two n-bit values, and the sum never leaves 2n bits.
  always_comb begin
    s2_pix_nxt = s1_pix_r;
    for (int k = 0; k < COMPS; k++) begin
      quot_sum[k] = s1_prod_r[k] + (s1_prod_r[k] >> SAMPLE_BITS) + PW'(1);
      shade[k]    = SMAX - quot_sum[k][PW-1:SAMPLE_BITS];
      if (active && (shade[k] < s1_pix_r.comp[k][SAMPLE_BITS-1:0])) begin
        s2_pix_nxt.comp[k] = FIELD_W'(shade[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pix_r  <= in_pix;
      s1_prod_r <= s1_prod_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_pix_r <= s2_pix_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_pix   = s2_pix_r;

endmodule

// File: hdl/ink_to_rgb_preview.sv
// Top level of the ink-to-RGB preview: configuration registers and the chain of ink cells.
//
// Usage: pixels enter on the in_ channel (valid/ready), one beat per pixel,
// carrying up to six ink amounts and an alpha sample. Each beat yields exactly
// one beat on the out_ channel with red, green, blue and alpha_out.
// The chain holds one cell per ink, MIN(MAX_INKS, 6) cells, and each cell has
// two register stages (multiply, then divide and take the minimum).
// Throughput is one pixel per clock; a new beat is taken every cycle while
// the output is drained.
// The last cell's second stage is the output register. When the receiver
// holds out_ready low, each stage keeps its beat and in_ready falls only once
// every stage ahead is full, so bubbles in the chain still take new beats.
// Configuration beats on the cfg_ channel are always taken (cfg_ready is
// high) and must only be sent while no pixel is in flight. Indices 0 to 5
// set the ink colours, 6 the number of active inks and 7 alpha mode.
// Synchronous reset empties the chain, clears the colours to black, sets one
// active ink and turns alpha mode off.
module ink_to_rgb_preview import itrp_pkg::*; #(
  parameter int MAX_INKS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FIELD_W-1:0]   in_ink_0,
  input  logic [FIELD_W-1:0]   in_ink_1,
  input  logic [FIELD_W-1:0]   in_ink_2,
  input  logic [FIELD_W-1:0]   in_ink_3,
  input  logic [FIELD_W-1:0]   in_ink_4,
  input  logic [FIELD_W-1:0]   in_ink_5,
  input  logic [FIELD_W-1:0]   in_alpha_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FIELD_W-1:0]   out_red,
  output logic [FIELD_W-1:0]   out_green,
  output logic [FIELD_W-1:0]   out_blue,
  output logic [FIELD_W-1:0]   out_alpha_out
);

  localparam int INK_CELLS = (MAX_INKS < INK_FIELDS) ? MAX_INKS : INK_FIELDS;
  localparam logic [FIELD_W-1:0] SMAX16 = FIELD_W'((1 << SAMPLE_BITS) - 1);

  logic [INK_FIELDS-1:0][COLOUR_W-1:0] colour_r;
  logic [INK_CNT_W-1:0]                active_inks_r;
  logic                                alpha_mode_r;

  logic      chain_valid [INK_CELLS+1];
  logic      chain_ready [INK_CELLS+1];
  itrp_pix_t chain_pix   [INK_CELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r      <= '0;
      active_inks_r <= INK_CNT_W'(1);
      alpha_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < INK_FIELDS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          colour_r[i] <= cfg_data;
        end
      end
      if (cfg_index == CFG_ACTIVE_INKS) begin
        active_inks_r <= cfg_data[INK_CNT_W-1:0];
      end
      if (cfg_index == CFG_ALPHA_MODE) begin
        alpha_mode_r <= cfg_data[0];
      end
    end
  end

  // Every pixel starts out white; alpha is settled here, as the user must keep the
  // mode static while pixels are in flight; the block itself does not enforce it.
  always_comb begin
    chain_pix[0].amt[0] = in_ink_0;
    chain_pix[0].amt[1] = in_ink_1;
    chain_pix[0].amt[2] = in_ink_2;
    chain_pix[0].amt[3] = in_ink_3;
    chain_pix[0].amt[4] = in_ink_4;
    chain_pix[0].amt[5] = in_ink_5;
    for (int k = 0; k < COMPS; k++) begin
      chain_pix[0].comp[k] = SMAX16;
    end
    chain_pix[0].alpha = alpha_mode_r ? in_alpha_in : '0;
  end

  assign chain_valid[0] = in_valid;
  assign in_ready       = chain_ready[0];

  for (genvar g = 0; g < INK_CELLS; g++) begin : g_cell
    logic ink_active;
    assign ink_active = active_inks_r > INK_CNT_W'(g);

    itrp_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .INK_IDX     (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_pix    (chain_pix[g]),
      .colour    (colour_r[g]),
      .active    (ink_active),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_pix   (chain_pix[g+1])
    );
  end

  assign chain_ready[INK_CELLS] = out_ready;
  assign out_valid              = chain_valid[INK_CELLS];
  assign out_red                = chain_pix[INK_CELLS].comp[RED];
  assign out_green              = chain_pix[INK_CELLS].comp[GREEN];
  assign out_blue               = chain_pix[INK_CELLS].comp[BLUE];
  assign out_alpha_out          = chain_pix[INK_CELLS].alpha;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat presented straight after reset");

  a_alpha_off : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !alpha_mode_r |-> out_alpha_out == '0)
    else $error("alpha passed through with alpha mode off");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= SMAX16) && (out_green <= SMAX16) && (out_blue <= SMAX16))
    else $error("colour component exceeds the sample range");

  a_no_inks : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && active_inks_r == '0 |->
      out_red == SMAX16 && out_green == SMAX16 && out_blue == SMAX16)
    else $error("pixel with no active ink is not white");

endmodule
